@@ rtl/core/crc32rs_pkg.sv @@
// Shared types, constants and the reflected CRC-32 byte step.
package crc32rs_pkg;

   localparam int unsigned CrcWidth      = 32;
   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned BytesPerWord  = 4;
   localparam int unsigned PaletteBytes  = 2;
   localparam int unsigned CountWidth    = 3;
   localparam logic [CrcWidth-1:0] PolyReflected = 32'hEDB8_8320;

   typedef struct packed {
      logic [CrcWidth-1:0]   data_word;
      logic [CountWidth-1:0] byte_count;
      logic                  first;
      logic [CrcWidth-1:0]   seed;
      logic                  last;
   } item_type;

   typedef struct packed {
      logic [CrcWidth-1:0] running_crc;
      logic [CrcWidth-1:0] held_seed;
      logic                group_half;
   } state_type;

   // One byte through the reflected CRC, least significant bit first.
   function automatic logic [CrcWidth-1:0] crc_byte(
      input logic [CrcWidth-1:0]  crc,
      input logic [ByteWidth-1:0] data
   );
      logic [CrcWidth-1:0] c;
      c = crc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
      for (int k = 0; k < ByteWidth; k++) begin
         c = c[0] ? ((c >> 1) ^ PolyReflected) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/core/crc32rs_update.sv @@
// Next-state logic: seed load, up to four byte steps and the palette grouping.
module crc32rs_update
   import crc32rs_pkg::*;
(
   input  item_type  item,
   input  state_type state,
   input  logic      palette_mode,
   output state_type next_state
);

   state_type           base;
   logic [CrcWidth-1:0] crc;
   logic                hash_byte;

   always_comb begin
      if (item.first) begin
         base.running_crc = item.seed;
         base.held_seed   = item.seed;
         base.group_half  = 1'b0;
      end else begin
         base = state;
      end

      crc = base.running_crc;
      for (int i = 0; i < BytesPerWord; i++) begin
         if (palette_mode) begin
            hash_byte = !base.group_half && (i < PaletteBytes);
         end else begin
            // A count above four hashes all four bytes; zero hashes none.
            hash_byte = item.byte_count > CountWidth'(i);
         end
         if (hash_byte) begin
            crc = crc_byte(crc, item.data_word[i*ByteWidth +: ByteWidth]);
         end
      end

      next_state.running_crc = crc;
      next_state.held_seed   = base.held_seed;
      next_state.group_half  = palette_mode ? !base.group_half : base.group_half;
   end

endmodule

@@ rtl/core/crc32_reflected_seeded_stream_top.sv @@
// Top level of the seeded reflected CRC-32 stream block.
//
//   channel  | ports                                            | direction
//   ---------+--------------------------------------------------+----------
//   request  | req_valid, req_stall, req_data_word, req_byte_count,
//            | req_first, req_seed, req_last                    | in
//   response | rsp_valid, rsp_stall, rsp_checksum               | out
//   csr      | csr_write_enable, csr_write_data (palette_mode)  | in
//
// One item per cycle is taken while req_stall is low: a transfer lands in the input
// register and is folded into the running CRC from there, and rsp_valid is registered
// and rises once a last item leaves the input register. Reset is synchronous and
// clears the CRC state, the palette mode and both valid flags. A stalled response
// holds the input register only when it carries a last item.
module crc32_reflected_seeded_stream_top
   import crc32rs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CrcWidth-1:0]   req_data_word,
   input  logic [CountWidth-1:0] req_byte_count,
   input  logic                  req_first,
   input  logic [CrcWidth-1:0]   req_seed,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CrcWidth-1:0]   rsp_checksum,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   item_type            item_ff, item_in;
   logic                item_valid_ff;
   state_type           state_ff, state_in;
   logic                palette_mode_ff;
   logic                rsp_valid_ff;
   logic [CrcWidth-1:0] checksum_ff;
   logic                out_free;
   logic                item_advance;
   logic                req_accept;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign item_advance = item_valid_ff && (!item_ff.last || out_free);
   assign req_stall    = item_valid_ff && !item_advance;
   assign req_accept   = req_valid && !req_stall;

   assign item_in.data_word  = req_data_word;
   assign item_in.byte_count = req_byte_count;
   assign item_in.first      = req_first;
   assign item_in.seed       = req_seed;
   assign item_in.last       = req_last;

   crc32rs_update u_update (
      .item         (item_ff),
      .state        (state_ff),
      .palette_mode (palette_mode_ff),
      .next_state   (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         palette_mode_ff <= 1'b0;
         state_ff        <= '0;
      end else begin
         if (req_accept) begin
            item_valid_ff <= 1'b1;
         end else if (item_advance) begin
            item_valid_ff <= 1'b0;
         end
         if (item_advance && item_ff.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            palette_mode_ff <= csr_write_data;
         end
         if (item_advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
      if (item_advance && item_ff.last) begin
         checksum_ff <= state_in.running_crc ^ state_in.held_seed;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = checksum_ff;

endmodule

@@ rtl/core/crc32rs_checker.sv @@
// Port-level checks for the CRC stream block, bound to the top level.
module crc32rs_checker
   import crc32rs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  req_last,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [CrcWidth-1:0]   rsp_checksum
);

   // A response waiting on a stall keeps its checksum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_checksum))
      else $error("stalled checksum changed");

   // The request side backs up only behind a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // A fresh response always comes from an accepted last item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last, 2))
      else $error("response without a last item");

   // Nothing is reported right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind crc32_reflected_seeded_stream_top crc32rs_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_last     (req_last),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_checksum (rsp_checksum)
);

@@ test/crc32_reflected_seeded_stream_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the seeded reflected CRC-32 stream block.
module crc32_reflected_seeded_stream_top_tb;
   import crc32rs_pkg::*;

   localparam logic [CrcWidth-1:0] ReflectedPoly = 32'hEDB8_8320;
   localparam int unsigned MaxGap      = 8;
   localparam int unsigned DrainCycles = 6;
   localparam int unsigned HoldOff     = 150;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CrcWidth-1:0]   req_data_word;
   logic [CountWidth-1:0] req_byte_count;
   logic                  req_first;
   logic [CrcWidth-1:0]   req_seed;
   logic                  req_last;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [CrcWidth-1:0]   rsp_checksum;
   logic                  csr_write_enable;
   logic                  csr_write_data;

   // Predictor state, updated on every accepted request transfer; the palette flag follows CSR writes.
   logic [CrcWidth-1:0] model_crc;
   logic [CrcWidth-1:0] model_seed;
   logic                model_half;
   logic                model_palette;

   logic [CrcWidth-1:0] pending_checksums[$];
   logic [CrcWidth-1:0] wanted_checksum;
   int unsigned         error_count;
   int unsigned         hold_cycles;
   bit                  idle_on;

   crc32_reflected_seeded_stream_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_first        (req_first),
      .req_seed         (req_seed),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_checksum     (rsp_checksum),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic logic [CrcWidth-1:0] fold_byte(input logic [CrcWidth-1:0] crc,
                                                      input logic [7:0] data_byte);
      logic [CrcWidth-1:0] c;
      c = crc ^ {24'h0, data_byte};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (ReflectedPoly & {CrcWidth{c[0]}});
      end
      return c;
   endfunction

   function automatic void predict_checksum(input logic [CrcWidth-1:0] word,
                                            input logic [CountWidth-1:0] count,
                                            input logic is_first,
                                            input logic [CrcWidth-1:0] seed_value,
                                            input logic is_last);
      int unsigned n;
      if (is_first) begin
         model_crc  = seed_value;
         model_seed = seed_value;
         model_half = 1'b0;
      end
      if (model_palette) begin
         // Only the first item of each pair contributes, and only its two low bytes.
         if (!model_half) begin
            model_crc = fold_byte(model_crc, word[7:0]);
            model_crc = fold_byte(model_crc, word[15:8]);
         end
         model_half = ~model_half;
      end else begin
         n = (count > 4) ? 4 : count;
         for (int i = 0; i < n; i++) begin
            model_crc = fold_byte(model_crc, word[8*i +: 8]);
         end
      end
      if (is_last) begin
         pending_checksums.push_back(model_crc ^ model_seed);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [CrcWidth-1:0] want_value,
                                  input logic [CrcWidth-1:0] got_value);
      $display("mismatch on %s: expected %h, got %h at %0t", what, want_value, got_value,
               $realtime);
      error_count++;
   endtask

   // Offers one item; returns after its transfer, leaving valid high.
   task automatic send_item(input logic [CrcWidth-1:0] word, input logic [CountWidth-1:0] count,
                            input logic is_first, input logic [CrcWidth-1:0] seed_value,
                            input logic is_last);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, MaxGap) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= word;
      req_byte_count <= count;
      req_first      <= is_first;
      req_seed       <= seed_value;
      req_last       <= is_last;
      do @(posedge clock); while (req_stall);
      predict_checksum(word, count, is_first, seed_value, is_last);
   endtask

   task automatic drain_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_checksums.size() != 0) @(negedge clock);
      // Items without a result may still be folding in after the last checksum.
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_palette(input logic mode);
      drain_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      model_palette = mode;
   endtask

   function automatic logic [CountWidth-1:0] draw_count;
      if ($urandom_range(0, 9) < 8) return CountWidth'($urandom_range(1, 4));
      return CountWidth'($urandom_range(0, 7));
   endfunction

   // A well-formed message marks first and last; a noisy one gets random markers.
   task automatic send_message(input int unsigned len, input bit noisy);
      logic is_first;
      logic is_last;
      logic [CrcWidth-1:0] seed_value;
      seed_value = $urandom;
      for (int i = 0; i < len; i++) begin
         is_first = (i == 0);
         is_last  = (i == len - 1);
         if (noisy) begin
            is_first = 1'($urandom_range(0, 1));
            is_last  = 1'($urandom_range(0, 1));
            seed_value = $urandom;
         end
         send_item($urandom, draw_count(), is_first, seed_value, is_last);
      end
   endtask

   task automatic run_random_messages(input int unsigned item_total, input int unsigned noise_pct,
                                      input bit toggle_mode);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < item_total) begin
         idle_on = ($urandom_range(0, 3) != 0);
         len = $urandom_range(1, 8);
         send_message(len, $urandom_range(0, 99) < noise_pct);
         sent += len;
         if (toggle_mode && $urandom_range(0, 11) == 0) begin
            write_palette(~model_palette);
         end else if ($urandom_range(0, 19) == 0) begin
            // The sender pauses until every pending checksum has come back.
            drain_results();
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_reset_state;
      // Without a first item the CRC continues from the zero state left by reset.
      send_item(32'hFFFF_FFFF, 3'd4, 1'b0, 32'h1234_5678, 1'b1);
   endtask

   task automatic test_plain_extremes;
      write_palette(1'b0);
      for (int c = 0; c < 8; c++) begin
         send_item(c[0] ? 32'hFFFF_FFFF : 32'h0000_0000, CountWidth'(c), 1'b1,
                   c[1] ? 32'hFFFF_FFFF : 32'h0000_0000, 1'b1);
      end
      // A message goes on after its last item when no first follows.
      send_item(32'hA5C3_0F96, 3'd4, 1'b0, 32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_palette_groups;
      write_palette(1'b1);
      send_item(32'hFFFF_FFFF, 3'd0, 1'b1, 32'hDEAD_BEEF, 1'b0);
      send_item(32'hFFFF_FFFF, 3'd7, 1'b0, 32'h0, 1'b0);
      send_item(32'h0000_FFFF, 3'd4, 1'b0, 32'h0, 1'b1);
      // A first item in the middle of a group starts a new group.
      send_item(32'h1357_9BDF, 3'd1, 1'b1, 32'h0000_0000, 1'b0);
      send_item(32'h0246_8ACE, 3'd2, 1'b1, 32'hFFFF_FFFF, 1'b1);
   endtask

   task automatic test_mode_switch_in_message;
      write_palette(1'b0);
      send_item(32'h89AB_CDEF, 3'd3, 1'b1, 32'h5555_AAAA, 1'b0);
      write_palette(1'b1);
      send_item(32'h7654_3210, 3'd4, 1'b0, 32'h0, 1'b0);
      send_item(32'hFEDC_BA98, 3'd4, 1'b0, 32'h0, 1'b0);
      write_palette(1'b0);
      send_item(32'h0F0F_F0F0, 3'd2, 1'b0, 32'h0, 1'b1);
   endtask

   task automatic test_random_plain;
      write_palette(1'b0);
      run_random_messages(330, 10, 1'b0);
   endtask

   task automatic test_random_palette;
      write_palette(1'b1);
      run_random_messages(330, 10, 1'b0);
   endtask

   task automatic test_output_backpressure;
      drain_results();
      idle_on = 1'b0;
      hold_cycles = HoldOff;
      for (int i = 0; i < 40; i++) begin
         send_item($urandom, draw_count(), 1'b1, $urandom, 1'b1);
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_mixed;
      run_random_messages(300, 15, 1'b1);
      write_palette(1'b0);
   endtask

   // Response side: a random hold-off before each result, or a long one on request.
   initial begin
      int unsigned gap;
      rsp_stall = 1'b0;
      forever begin
         gap = idle_on ? $urandom_range(0, MaxGap) : 0;
         if (hold_cycles > 0) begin
            gap = hold_cycles;
            hold_cycles = 0;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_checksums.size() == 0) begin
            report_mismatch("unexpected checksum", 32'h0, rsp_checksum);
         end else begin
            wanted_checksum = pending_checksums.pop_front();
            if (rsp_checksum !== wanted_checksum) begin
               report_mismatch("checksum", wanted_checksum, rsp_checksum);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL crc32_reflected_seeded_stream_top");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_word    = '0;
      req_byte_count   = '0;
      req_first        = 1'b0;
      req_seed         = '0;
      req_last         = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      idle_on          = 1'b1;
      hold_cycles      = 0;
      error_count      = 0;
      model_crc        = '0;
      model_seed       = '0;
      model_half       = 1'b0;
      model_palette    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_plain_extremes();
      test_palette_groups();
      test_mode_switch_in_message();
      test_random_plain();
      test_random_palette();
      test_output_backpressure();
      test_random_mixed();
      drain_results();

      if (error_count == 0) begin
         $display("PASS crc32_reflected_seeded_stream_top");
      end else begin
         $display("FAIL crc32_reflected_seeded_stream_top");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/crc32rs_pkg.sv
rtl/core/crc32rs_update.sv
rtl/core/crc32_reflected_seeded_stream_top.sv
rtl/core/crc32rs_checker.sv
test/crc32_reflected_seeded_stream_top_tb.sv
